// ===== design/glob_pkg.sv =====
// Shared types and constants for the glob pattern matcher.
// Used by glob_ctrl, glob_dp and glob_pattern_matcher; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package glob_pkg;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_QUES = 8'h3F;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_EXCL = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_RBR  = 8'h5D;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STR  = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  localparam logic [1:0] SEL_I  = 2'd0;
  localparam logic [1:0] SEL_J  = 2'd1;
  localparam logic [1:0] SEL_J1 = 2'd2;
  localparam logic [1:0] SEL_J2 = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       load_wr;
    logic       seed_init;
    logic       adv_init;
    logic       inc_i;
    logic       set_j_i;
    logic       set_j_i1;
    logic       inc_j;
    logic       add_j3;
    logic       br_init;
    logic       set_neg;
    logic       mark;
    logic       seed_fin;
    logic       adv_fin;
    logic       set_dead;
    logic       load_c0;
    logic       load_c1;
    logic       hit_range;
    logic       hit_c0;
    logic       end_out;
    logic [1:0] addr_sel;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic dead;
    logic i_ge_len;
    logic j_ge_len;
    logic live_i;
    logic rd_star;
    logic rd_lbr;
    logic rd_neg;
    logic rd_rbr;
    logic rd_q_or_eq;
    logic range_take;
    logic br_hit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/glob_dp.sv =====
// Datapath of the glob pattern matcher: pattern memory, live and next position sets,
// scan pointers, bracket class registers and the result register. Uses glob_pkg.
`timescale 1ns / 1ps
`default_nettype none

module glob_dp #(
  parameter int PATTERN_MAX = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire  [6:0]           cfg_wr_data,
  input  wire  [5:0]           pattern_index,
  input  wire  [7:0]           data_byte,
  input  wire glob_pkg::cmd_t  cmd,
  output glob_pkg::sts_t       sts,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_matched
);
  import glob_pkg::*;

  localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PW = $clog2(PATTERN_MAX + 1);

  logic [7:0]             mem [PATTERN_MAX];
  logic [7:0]             rd_r;
  logic [AW-1:0]          rd_addr;
  logic [6:0]             cfg_len_r;
  logic [PW-1:0]          len_eff;
  logic [PATTERN_MAX:0]   live_r, live_nxt;
  logic [PATTERN_MAX:0]   nxt_r, nxt_nxt;
  logic [PATTERN_MAX:0]   keep;
  logic [PW-1:0]          i_r, i_nxt;
  logic [PW-1:0]          j_r, j_nxt;
  logic [PW:0]            j2;
  logic [7:0]             byte_r, c0_r, c1_r;
  logic                   hit_r, hit_nxt, neg_r, neg_nxt;
  logic                   started_r, started_nxt, dead_r, dead_nxt;
  logic                   out_valid_r, out_valid_nxt, out_matched_r;

  assign len_eff = (int'(cfg_len_r) < PATTERN_MAX) ? PW'(cfg_len_r) : PW'(PATTERN_MAX);
  assign j2 = {1'b0, j_r} + (PW + 1)'(2);

  always_comb begin
    for (int k = 0; k <= PATTERN_MAX; k++) begin
      keep[k] = (k <= int'(len_eff));
    end
  end

  always_comb begin
    unique case (cmd.addr_sel)
      SEL_I:   rd_addr = i_r[AW-1:0];
      SEL_J:   rd_addr = j_r[AW-1:0];
      SEL_J1:  rd_addr = AW'(j_r + PW'(1));
      SEL_J2:  rd_addr = AW'(j_r + PW'(2));
      default: rd_addr = j_r[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && int'(pattern_index) < PATTERN_MAX) begin
      mem[AW'(pattern_index)] <= data_byte;
    end
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    live_nxt      = live_r;
    nxt_nxt       = nxt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    hit_nxt       = hit_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    dead_nxt      = dead_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.accept) begin
      live_nxt = live_r & keep;
    end
    if (cmd.seed_init || cmd.adv_init) begin
      nxt_nxt = '0;
    end
    if (cmd.mark) begin
      nxt_nxt[j_r] = 1'b1;
    end
    if (cmd.seed_fin) begin
      live_nxt    = nxt_r;
      started_nxt = 1'b1;
    end
    if (cmd.adv_fin) begin
      live_nxt = nxt_r;
      if (nxt_r == '0) begin
        dead_nxt = 1'b1;
      end
    end
    if (cmd.set_dead) begin
      dead_nxt = 1'b1;
    end
    if (cmd.adv_init) begin
      i_nxt = '0;
    end else if (cmd.inc_i) begin
      i_nxt = i_r + PW'(1);
    end
    priority if (cmd.seed_init) begin
      j_nxt = '0;
    end else if (cmd.set_j_i) begin
      j_nxt = i_r;
    end else if (cmd.set_j_i1 || cmd.br_init) begin
      j_nxt = i_r + PW'(1);
    end else if (cmd.inc_j) begin
      j_nxt = j_r + PW'(1);
    end else if (cmd.add_j3) begin
      j_nxt = j_r + PW'(3);
    end else begin
      j_nxt = j_r;
    end
    if (cmd.br_init) begin
      hit_nxt = 1'b0;
      neg_nxt = 1'b0;
    end
    if (cmd.set_neg) begin
      neg_nxt = 1'b1;
    end
    if (cmd.hit_range && byte_r >= c0_r && byte_r <= rd_r) begin
      hit_nxt = 1'b1;
    end
    if (cmd.hit_c0 && byte_r == c0_r) begin
      hit_nxt = 1'b1;
    end
    if (cmd.end_out) begin
      out_valid_nxt = 1'b1;
      live_nxt      = '0;
      started_nxt   = 1'b0;
      dead_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= '0;
      live_r      <= '0;
      started_r   <= 1'b0;
      dead_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      live_r      <= live_nxt;
      started_r   <= started_nxt;
      dead_r      <= dead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nxt_r <= nxt_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    hit_r <= hit_nxt;
    neg_r <= neg_nxt;
    if (cmd.accept) begin
      byte_r <= data_byte;
    end
    if (cmd.load_c0) begin
      c0_r <= rd_r;
    end
    if (cmd.load_c1) begin
      c1_r <= rd_r;
    end
    if (cmd.end_out) begin
      out_matched_r <= !dead_r && live_r[len_eff];
    end
  end

  always_comb begin
    sts.started    = started_r;
    sts.dead       = dead_r;
    sts.i_ge_len   = (i_r >= len_eff);
    sts.j_ge_len   = (j_r >= len_eff);
    sts.live_i     = live_r[i_r];
    sts.rd_star    = (rd_r == CH_STAR);
    sts.rd_lbr     = (rd_r == CH_LBR);
    sts.rd_neg     = (rd_r == CH_EXCL) || (rd_r == CH_CARET);
    sts.rd_rbr     = (rd_r == CH_RBR);
    sts.rd_q_or_eq = (rd_r == CH_QUES) || (rd_r == byte_r);
    sts.range_take = (j2 < {1'b0, len_eff}) && (c1_r == CH_DASH) && (rd_r != CH_RBR);
    sts.br_hit     = hit_r != neg_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  a_dead_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    dead_r |-> started_r) else $error("match marked dead outside a string");
  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> (j_r <= len_eff)) else $error("position marked beyond pattern end");
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_out |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !started_r && !dead_r)) else $error("reset state wrong");

endmodule

`default_nettype wire

// ===== design/glob_ctrl.sv =====
// Controller of the glob pattern matcher: sequences seeding, position scans,
// star skips and bracket class walks. Uses glob_pkg; drives glob_dp by commands.
`timescale 1ns / 1ps
`default_nettype none

module glob_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire  [1:0]           in_req,
  output logic                 in_ready,
  input  wire glob_pkg::sts_t  sts,
  output glob_pkg::cmd_t       cmd
);
  import glob_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_SEED      = 5'd1;
  localparam logic [4:0] S_SK_MARK   = 5'd2;
  localparam logic [4:0] S_SK_CHK    = 5'd3;
  localparam logic [4:0] S_SK_DAT    = 5'd4;
  localparam logic [4:0] S_SEED_FIN  = 5'd5;
  localparam logic [4:0] S_ADV_START = 5'd6;
  localparam logic [4:0] S_ADV_CHK   = 5'd7;
  localparam logic [4:0] S_ADV_DAT   = 5'd8;
  localparam logic [4:0] S_BR_NEG    = 5'd9;
  localparam logic [4:0] S_BR_NEGD   = 5'd10;
  localparam logic [4:0] S_BR_BEG    = 5'd11;
  localparam logic [4:0] S_BR_D0     = 5'd12;
  localparam logic [4:0] S_BR_D1     = 5'd13;
  localparam logic [4:0] S_BR_D2     = 5'd14;
  localparam logic [4:0] S_BR_END    = 5'd15;
  localparam logic [4:0] S_BR_ENDD   = 5'd16;
  localparam logic [4:0] S_END_OUT   = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       seed_mode_r, seed_mode_nxt;
  logic       is_end_r, is_end_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.addr_sel  = SEL_J;
    state_nxt     = state_r;
    seed_mode_nxt = seed_mode_r;
    is_end_nxt    = is_end_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req)
            REQ_LOAD: begin
              cmd.load_wr = 1'b1;
            end
            REQ_STR: begin
              cmd.accept = 1'b1;
              is_end_nxt = 1'b0;
              if (!sts.started) begin
                state_nxt = S_SEED;
              end else if (!sts.dead) begin
                state_nxt = S_ADV_START;
              end
            end
            REQ_END: begin
              cmd.accept = 1'b1;
              is_end_nxt = 1'b1;
              state_nxt  = sts.started ? S_END_OUT : S_SEED;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEED: begin
        cmd.seed_init = 1'b1;
        seed_mode_nxt = 1'b1;
        state_nxt     = S_SK_MARK;
      end
      S_SK_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_SK_CHK;
      end
      S_SK_CHK: begin
        if (sts.j_ge_len) begin
          cmd.mark = 1'b1;
          if (seed_mode_r) begin
            state_nxt = S_SEED_FIN;
          end else begin
            cmd.inc_i = 1'b1;
            state_nxt = S_ADV_CHK;
          end
        end else begin
          state_nxt = S_SK_DAT;
        end
      end
      S_SK_DAT: begin
        if (sts.rd_star) begin
          cmd.inc_j = 1'b1;
          state_nxt = S_SK_CHK;
        end else begin
          cmd.mark = 1'b1;
          if (seed_mode_r) begin
            state_nxt = S_SEED_FIN;
          end else begin
            cmd.inc_i = 1'b1;
            state_nxt = S_ADV_CHK;
          end
        end
      end
      S_SEED_FIN: begin
        cmd.seed_fin = 1'b1;
        state_nxt    = is_end_r ? S_END_OUT : S_ADV_START;
      end
      S_ADV_START: begin
        cmd.adv_init  = 1'b1;
        seed_mode_nxt = 1'b0;
        state_nxt     = S_ADV_CHK;
      end
      S_ADV_CHK: begin
        cmd.addr_sel = SEL_I;
        if (sts.i_ge_len) begin
          cmd.adv_fin = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!sts.live_i) begin
          cmd.inc_i = 1'b1;
        end else begin
          state_nxt = S_ADV_DAT;
        end
      end
      S_ADV_DAT: begin
        if (sts.rd_star) begin
          cmd.set_j_i = 1'b1;
          state_nxt   = S_SK_MARK;
        end else if (sts.rd_lbr) begin
          cmd.br_init = 1'b1;
          state_nxt   = S_BR_NEG;
        end else if (sts.rd_q_or_eq) begin
          cmd.set_j_i1 = 1'b1;
          state_nxt    = S_SK_MARK;
        end else begin
          cmd.inc_i = 1'b1;
          state_nxt = S_ADV_CHK;
        end
      end
      S_BR_NEG: begin
        if (sts.j_ge_len) begin
          cmd.set_dead = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_BR_NEGD;
        end
      end
      S_BR_NEGD: begin
        if (sts.rd_neg) begin
          cmd.inc_j   = 1'b1;
          cmd.set_neg = 1'b1;
        end
        state_nxt = S_BR_BEG;
      end
      S_BR_BEG: begin
        if (sts.j_ge_len) begin
          cmd.set_dead = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_BR_D0;
        end
      end
      S_BR_D0: begin
        cmd.load_c0  = 1'b1;
        cmd.addr_sel = SEL_J1;
        state_nxt    = S_BR_D1;
      end
      S_BR_D1: begin
        cmd.load_c1  = 1'b1;
        cmd.addr_sel = SEL_J2;
        state_nxt    = S_BR_D2;
      end
      S_BR_D2: begin
        if (sts.range_take) begin
          cmd.hit_range = 1'b1;
          cmd.add_j3    = 1'b1;
        end else begin
          cmd.hit_c0 = 1'b1;
          cmd.inc_j  = 1'b1;
        end
        state_nxt = S_BR_END;
      end
      S_BR_END: begin
        if (sts.j_ge_len) begin
          cmd.set_dead = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_BR_ENDD;
        end
      end
      S_BR_ENDD: begin
        if (!sts.rd_rbr) begin
          state_nxt = S_BR_BEG;
        end else if (sts.br_hit) begin
          cmd.inc_j = 1'b1;
          state_nxt = S_SK_MARK;
        end else begin
          cmd.inc_i = 1'b1;
          state_nxt = S_ADV_CHK;
        end
      end
      S_END_OUT: begin
        if (sts.out_free) begin
          cmd.end_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_mode_r <= 1'b0;
      is_end_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_mode_r <= seed_mode_nxt;
      is_end_r    <= is_end_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/glob_pattern_matcher.sv =====
// Glob pattern matcher top level: stream ports, controller and datapath.
// Depends on glob_pkg, glob_ctrl and glob_dp.
//
// Items enter on the in_ channel. in_tuser carries the request kind: load a
// pattern byte, match a string byte, or end the string. A load, an unused
// request or a byte after the match has failed is taken while the block stays
// idle. The first byte or end item of a string seeds the live set with
// position 0 and the position after any leading stars. A string byte then
// walks every position below the pattern length L: a live star, a matching
// literal or '?' and a hitting bracket class mark their successors, skipping
// stars; an unterminated class fails the match. The walk is serial through
// the single read port of the memory, and no new item is taken until it is
// done. An end item waits in S_END_OUT for a free output register before
// out_tvalid rises, after the seed walk if no byte came before it. Bit 0 of
// out_tdata is the match bit. The result waits in an output register while
// out_tready is low; further items are still taken, and a following end item
// waits for the register. cfg_wr_en writes the pattern length; the user must
// write it only while the block is idle, as the block does not enforce it.
// Reset clears the live set, the result valid flag and the length; the
// pattern memory holds nothing defined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module glob_pattern_matcher #(
  parameter int PATTERN_MAX = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [6:0]  cfg_wr_data,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // pattern_index [5:0], data_byte [13:6], zeros above
  input  wire  [1:0]  in_tuser,   // req_type [1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata   // matched [0], zeros above
);
  import glob_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic matched;

  glob_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_req   (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  glob_dp #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .pattern_index (in_tdata[5:0]),
    .data_byte     (in_tdata[13:6]),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_matched   (matched)
  );

  assign out_tdata = {7'b0, matched};

endmodule

`default_nettype wire

// ===== verif/glob_pattern_matcher_test.sv =====
// Self-checking testbench for glob_pattern_matcher: loads glob patterns,
// streams strings and compares each match bit with a built-in predictor.
// Depends on glob_pkg and the glob_pattern_matcher RTL.
`timescale 1ns / 1ps

module glob_pattern_matcher_test;
  import glob_pkg::*;

  localparam int PMAX = 64;
  localparam int WATCHDOG = 100000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [5:0] idx;
    logic [7:0] data;
    int         want;
  } req_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  logic [7:0] pat_mem [PMAX];
  logic       live_set [PMAX + 1];
  bit         str_started;
  bit         str_dead;
  int         pat_len;
  logic       match_queue [$];
  int         mismatches;
  int         results_seen;
  int         items_sent;
  int         idle_cycles;
  int         rx_gap;
  bit         rx_idle_ok;
  bit         hold_rx;
  bit         timed_out;
  req_row_t   directed [$];

  glob_pattern_matcher #(.PATTERN_MAX(PMAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int skip_stars(int k);
    while (k < pat_len && pat_mem[k] == CH_STAR) k++;
    return k;
  endfunction

  // Returns 1 on a hit, 0 on a miss and -1 when the class is unterminated.
  function automatic int class_match(int i, logic [7:0] b, output int nxt);
    int  j;
    bit  hit;
    bit  neg;
    j = i + 1;
    hit = 0;
    neg = 0;
    nxt = 0;
    if (j < pat_len && (pat_mem[j] == CH_EXCL || pat_mem[j] == CH_CARET)) begin
      j++;
      neg = 1;
    end
    if (j >= pat_len) return -1;
    do begin
      if (j + 2 < pat_len && pat_mem[j + 1] == CH_DASH && pat_mem[j + 2] != CH_RBR) begin
        if (b >= pat_mem[j] && b <= pat_mem[j + 2]) hit = 1;
        j += 3;
      end else begin
        if (b == pat_mem[j]) hit = 1;
        j++;
      end
      if (j >= pat_len) return -1;
    end while (pat_mem[j] != CH_RBR);
    nxt = j + 1;
    return (hit != neg) ? 1 : 0;
  endfunction

  function automatic void seed_live();
    for (int k = 0; k <= PMAX; k++) live_set[k] = 0;
    live_set[0] = 1;
    live_set[skip_stars(0)] = 1;
    str_started = 1;
  endfunction

  function automatic void step_string(logic [7:0] b);
    logic nxt_set [PMAX + 1];
    bit   any;
    int   r;
    int   j;
    any = 0;
    for (int k = 0; k <= PMAX; k++) nxt_set[k] = 0;
    for (int i = 0; i < pat_len; i++) begin
      if (live_set[i]) begin
        if (pat_mem[i] == CH_STAR) begin
          nxt_set[i] = 1;
          nxt_set[skip_stars(i + 1)] = 1;
        end else if (pat_mem[i] == CH_LBR) begin
          r = class_match(i, b, j);
          if (r < 0) begin
            str_dead = 1;
            return;
          end
          if (r > 0) begin
            nxt_set[j] = 1;
            nxt_set[skip_stars(j)] = 1;
          end
        end else if (pat_mem[i] == CH_QUES || pat_mem[i] == b) begin
          nxt_set[i + 1] = 1;
          nxt_set[skip_stars(i + 1)] = 1;
        end
      end
    end
    for (int k = 0; k <= PMAX; k++) begin
      live_set[k] = nxt_set[k];
      if (nxt_set[k]) any = 1;
    end
    if (!any) str_dead = 1;
  endfunction

  // Updates the predicted state for one accepted item; returns the match bit
  // for an end item and -1 otherwise.
  function automatic int predict_match(logic [1:0] kind, logic [5:0] idx, logic [7:0] b);
    int m;
    m = -1;
    case (kind)
      REQ_LOAD: pat_mem[idx] = b;
      REQ_STR: begin
        if (!str_started) seed_live();
        for (int k = pat_len + 1; k <= PMAX; k++) live_set[k] = 0;
        if (!str_dead) step_string(b);
      end
      REQ_END: begin
        if (!str_started) seed_live();
        for (int k = pat_len + 1; k <= PMAX; k++) live_set[k] = 0;
        m = (!str_dead && live_set[pat_len]) ? 1 : 0;
        for (int k = 0; k <= PMAX; k++) live_set[k] = 0;
        str_started = 0;
        str_dead = 0;
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_item(logic [1:0] kind, logic [5:0] idx, logic [7:0] b, int want);
    int m;
    if (rx_idle_ok && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, b, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    m = predict_match(kind, idx, b);
    if (m >= 0) begin
      if (want >= 0 && want != m)
        report_mismatch($sformatf("predictor gives %0d, table expects %0d", m, want));
      match_queue.push_back(m[0]);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (match_queue.size() != 0) @(posedge clk);
    repeat (8 * PMAX + 20) @(posedge clk);
  endtask

  task automatic write_length(int len);
    in_tvalid   <= 1'b0;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len[6:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pat_len = (len < PMAX) ? len : PMAX;
  endtask

  task automatic load_pattern(string p);
    for (int k = 0; k < p.len(); k++) send_item(REQ_LOAD, k[5:0], p[k], -1);
  endtask

  task automatic send_string(string s);
    for (int k = 0; k < s.len(); k++) send_item(REQ_STR, 6'd0, s[k], -1);
    send_item(REQ_END, 6'd0, 8'd0, -1);
  endtask

  function automatic logic [7:0] rand_pat_byte();
    case ($urandom_range(0, 9))
      0: return CH_STAR;
      1: return CH_QUES;
      2: return CH_LBR;
      3: return CH_RBR;
      4: return CH_DASH;
      5: return ($urandom_range(0, 1) != 0) ? CH_EXCL : CH_CARET;
      6: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h61, 8'h64));
    endcase
  endfunction

  // Builds a random pattern of length len and loads it, filling every slot.
  task automatic random_pattern(int len);
    for (int k = 0; k < len; k++) send_item(REQ_LOAD, k[5:0], rand_pat_byte(), -1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (match_queue.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        if (out_tdata[0] !== match_queue[0])
          report_mismatch($sformatf("matched %b, expected %b", out_tdata[0], match_queue[0]));
        if (out_tdata[7:1] !== 7'd0)
          report_mismatch("nonzero padding in out_tdata");
        void'(match_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap     <= 0;
    end else if (hold_rx) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= 1'b0;
    end else if (rx_idle_ok && out_tready && $urandom_range(0, 4) == 0) begin
      rx_gap     <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !timed_out) begin
        timed_out = 1;
        $display("Watchdog expired after %0d idle cycles", WATCHDOG);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int len;
    string p;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_LOAD;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    rx_idle_ok = 1;
    hold_rx = 0;
    timed_out = 0;
    pat_len = 0;
    str_started = 0;
    str_dead = 0;
    for (int k = 0; k < PMAX; k++) pat_mem[k] = 8'd0;
    for (int k = 0; k <= PMAX; k++) live_set[k] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pattern: an empty string matches, any byte kills the match.
    directed.push_back('{REQ_END, 6'd0, 8'h00, 1});
    directed.push_back('{REQ_STR, 6'd0, 8'hFF, -1});
    directed.push_back('{REQ_END, 6'd0, 8'h00, 0});
    directed.push_back('{REQ_UNUSED, 6'd63, 8'hFF, -1});
    foreach (directed[k])
      send_item(directed[k].kind, directed[k].idx, directed[k].data, directed[k].want);
    directed.delete();
    drain_results();

    // A pattern that exercises star, question mark, ranges and negation.
    p = "*a?[!]x-z]*";
    load_pattern(p);
    write_length(p.len());
    directed.push_back('{REQ_STR, 6'd0, 8'h61, -1});
    directed.push_back('{REQ_STR, 6'd0, 8'h00, -1});
    directed.push_back('{REQ_STR, 6'd0, 8'h62, -1});
    directed.push_back('{REQ_END, 6'd0, 8'h00, 1});
    directed.push_back('{REQ_STR, 6'd0, 8'h61, -1});
    directed.push_back('{REQ_STR, 6'd0, 8'hFF, -1});
    directed.push_back('{REQ_STR, 6'd0, 8'h5D, -1});
    directed.push_back('{REQ_END, 6'd0, 8'h00, 0});
    directed.push_back('{REQ_LOAD, 6'd63, 8'hFF, -1});
    directed.push_back('{REQ_END, 6'd0, 8'h00, 0});
    foreach (directed[k])
      send_item(directed[k].kind, directed[k].idx, directed[k].data, directed[k].want);
    directed.delete();
    drain_results();

    // Unterminated class and a caret negation with a range.
    p = "[^a-c";
    load_pattern(p);
    write_length(p.len());
    send_string("d");
    drain_results();
    p = "[^]a-c]?";
    load_pattern(p);
    write_length(p.len());
    send_string("dq");
    send_string("bq");
    send_string("]");
    drain_results();

    // Full-size pattern of stars followed by the maximum length setting.
    for (int k = 0; k < PMAX; k++) send_item(REQ_LOAD, k[5:0], CH_STAR, -1);
    write_length(127);
    send_string("");
    send_string("zz");
    drain_results();

    // Pattern edited mid-string: overwrite a pattern byte with a string open.
    p = "ab*";
    load_pattern(p);
    write_length(3);
    send_item(REQ_STR, 6'd0, 8'h61, -1);
    send_item(REQ_LOAD, 6'd1, 8'h3F, -1);
    send_item(REQ_STR, 6'd0, 8'h7A, -1);
    send_item(REQ_END, 6'd0, 8'h00, -1);
    drain_results();

    // The receiver holds off while items keep coming so the block backs up.
    hold_rx = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_rx = 0;
      end
      for (int k = 0; k < 6; k++) send_string("ab");
    join
    drain_results();

    // Random phases: new length, full pattern load, then mostly strings.
    for (int ph = 0; items_sent < 440; ph++) begin
      if (ph == 0) len = PMAX;
      else if (ph == 1) len = 1;
      else len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, PMAX) : $urandom_range(1, 8);
      if (items_sent > 400) rx_idle_ok = 0;
      random_pattern((len > 0) ? len : 1);
      write_length(len);
      for (int s = 0; s < 6; s++) begin
        int slen;
        slen = $urandom_range(0, 6);
        for (int c = 0; c < slen; c++) begin
          logic [7:0] b;
          if ($urandom_range(0, 2) == 0) b = 8'($urandom_range(0, 255));
          else if (len > 0) b = pat_mem[$urandom_range(0, len - 1)];
          else b = 8'h61;
          if ($urandom_range(0, 15) == 0)
            send_item(REQ_LOAD, 6'($urandom_range(0, len > 0 ? len - 1 : 0)), rand_pat_byte(), -1);
          else if ($urandom_range(0, 20) == 0)
            send_item(REQ_UNUSED, 6'($urandom_range(0, 63)), b, -1);
          send_item(REQ_STR, 6'($urandom_range(0, 63)), b, -1);
        end
        send_item(REQ_END, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), -1);
      end
      drain_results();
    end

    drain_results();
    $display("Sent %0d items over directed and random patterns; checked %0d match results.",
             items_sent, results_seen);
    if (mismatches == 0 && match_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
